// ----- rtl/rtpl_pkg.sv -----
// Shared types and constants for the render target pool.
package rtpl_pkg;

    // Operation codes
    localparam logic [2:0] OP_ACQUIRE  = 3'd0;
    localparam logic [2:0] OP_PAIR     = 3'd1;
    localparam logic [2:0] OP_RELEASE  = 3'd2;
    localparam logic [2:0] OP_REL_ALL  = 3'd3;
    localparam logic [2:0] OP_TRIM     = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SIZE     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_POOL_LIMIT   = 2'd0;
    localparam logic [1:0] REG_WIDTH_LIMIT  = 2'd1;
    localparam logic [1:0] REG_HEIGHT_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [4:0]  POOL_LIMIT_RST = 5'd16;
    localparam logic [13:0] DIM_LIMIT_RST  = 14'd4096;

    // Slot scan kinds
    localparam logic [1:0] KIND_ACQ   = 2'd0;
    localparam logic [1:0] KIND_REL   = 2'd1;
    localparam logic [1:0] KIND_TRIM  = 2'd2;
    localparam logic [1:0] KIND_SWEEP = 2'd3;

    // Geometry and handle of one slot
    typedef struct packed {
        logic [13:0] width;
        logic [13:0] height;
        logic [31:0] handle;
    } geom_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       latch;
        logic       scan_start;
        logic [1:0] scan_kind;
        logic       set_size;
        logic       commit;
        logic       second;
        logic       rel_commit;
        logic       clear_all;
        logic       out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       size_bad;
        logic       scan_done;
        logic       acq_fail;
    } sts_t;

endpackage

// ----- rtl/rtpl_ctrl.sv -----
// Operation sequencer for the render target pool.
module rtpl_ctrl
    import rtpl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_COMMIT   = 3'd3;
    localparam logic [2:0] S_CHK1     = 3'd4;
    localparam logic [2:0] S_RCOMMIT  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                pass_next = 1'b0;
                case (sts.op)
                    OP_ACQUIRE, OP_PAIR:
                    begin
                        if (sts.size_bad)
                        begin
                            cmd.set_size = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_kind  = KIND_ACQ;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_RELEASE:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_kind  = KIND_REL;
                        state_next     = S_SCAN;
                    end
                    OP_REL_ALL:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_kind  = KIND_SWEEP;
                        state_next     = S_SCAN;
                    end
                    OP_TRIM:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_kind  = KIND_TRIM;
                        state_next     = S_SCAN;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.op == OP_ACQUIRE || sts.op == OP_PAIR)
                        state_next = S_COMMIT;
                    else if (sts.op == OP_RELEASE)
                        state_next = S_RCOMMIT;
                    else
                        state_next = S_DONE;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                cmd.second = pass_reg;
                state_next = (sts.op == OP_PAIR && !pass_reg) ? S_CHK1 : S_DONE;
            end
            S_CHK1:
            begin
                if (sts.acq_fail)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_kind  = KIND_ACQ;
                    pass_next      = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_RCOMMIT:
            begin
                cmd.rel_commit = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/rtpl_datapath.sv -----
// Slot table, slot scanner, limits and result registers of the pool.
module rtpl_datapath
    import rtpl_pkg::*;
#(
    parameter int POOL_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic [2:0]  opcode,
    input  logic [13:0] req_width,
    input  logic [13:0] req_height,
    input  logic [31:0] target_handle,
    input  logic [31:0] idle_limit_ms,
    input  logic [31:0] now_ms,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [2:0]  status,
    output logic [31:0] first_handle,
    output logic [31:0] second_handle,
    output logic [4:0]  freed_count,
    output logic [4:0]  entries_total,
    output logic [4:0]  entries_busy
);

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    // Configuration
    logic [4:0]  pool_limit_reg;
    logic [13:0] width_limit_reg, height_limit_reg;

    // Latched request
    logic [2:0]  op_reg;
    logic [13:0] w_reg, h_reg;
    logic [31:0] tgt_reg, idle_reg, now_reg;

    // Slot flags and counts
    logic [POOL_SLOTS-1:0] valid_reg, valid_next;
    logic [POOL_SLOTS-1:0] busy_reg, busy_next;
    logic [CW-1:0]         cnt_valid_reg, cnt_valid_next;
    logic [CW-1:0]         cnt_busy_reg, cnt_busy_next;
    logic [31:0]           next_handle_reg, next_handle_next;

    // Scanner
    logic          active_reg, active_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    kind_reg, kind_next;
    logic          rd_en, proc_en;
    logic [IW-1:0] rd_addr, proc_idx;

    // Scan results
    logic          m_found_reg, m_found_next;
    logic [IW-1:0] m_idx_reg, m_idx_next;
    logic [31:0]   m_hd_reg, m_hd_next;
    logic          v_found_reg, v_found_next;
    logic [IW-1:0] v_idx_reg, v_idx_next;
    logic [31:0]   v_lu_reg, v_lu_next;
    logic [31:0]   v_hd_reg, v_hd_next;
    logic          f_found_reg, f_found_next;
    logic [IW-1:0] f_idx_reg, f_idx_next;
    logic          h_found_reg, h_found_next;
    logic [IW-1:0] h_idx_reg, h_idx_next;
    logic [IW-1:0] s1_idx_reg, s1_idx_next;

    // Result
    logic [2:0]    res_status_reg, res_status_next;
    logic [31:0]   res_first_reg, res_first_next;
    logic [31:0]   res_second_reg, res_second_next;
    logic [CW-1:0] freed_reg, freed_next;

    // Memories
    geom_t         geom_mem [POOL_SLOTS];
    logic [31:0]   lu_mem [POOL_SLOTS];
    geom_t         geom_rd_reg;
    logic [31:0]   lu_rd_reg;
    logic          geom_we, lu_we;
    logic [IW-1:0] geom_wa, lu_wa;
    geom_t         geom_wd;

    // Limits and derived checks
    logic [13:0]   wl, hl;
    logic [LW-1:0] plim, lim;
    logic          evict;
    logic [IW-1:0] pick;
    logic [31:0]   nh_inc;

    assign wl      = (width_limit_reg == '0) ? 14'd1 : width_limit_reg;
    assign hl      = (height_limit_reg == '0) ? 14'd1 : height_limit_reg;
    assign plim    = LW'(pool_limit_reg);
    assign lim     = (plim == '0) ? LW'(1) :
                     (plim > LW'(POOL_SLOTS)) ? LW'(POOL_SLOTS) : plim;
    assign evict   = (LW'(cnt_valid_reg) >= lim);
    assign pick    = !evict ? f_idx_reg :
                     (f_found_reg && f_idx_reg < v_idx_reg) ? f_idx_reg : v_idx_reg;
    assign nh_inc  = (next_handle_reg + 32'd1 == '0) ? 32'd1 : next_handle_reg + 32'd1;

    assign rd_en    = active_reg && (cnt_reg < CW'(POOL_SLOTS));
    assign rd_addr  = cnt_reg[IW-1:0];
    assign proc_en  = active_reg && (cnt_reg != '0);
    assign proc_idx = IW'(cnt_reg - CW'(1));

    assign sts.op        = op_reg;
    assign sts.size_bad  = (w_reg > wl) || (h_reg > hl);
    assign sts.scan_done = active_reg && (cnt_reg == CW'(POOL_SLOTS));
    assign sts.acq_fail  = (res_status_reg != ST_OK);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_limit_reg   <= POOL_LIMIT_RST;
            width_limit_reg  <= DIM_LIMIT_RST;
            height_limit_reg <= DIM_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POOL_LIMIT:   pool_limit_reg   <= cfg_data[4:0];
                REG_WIDTH_LIMIT:  width_limit_reg  <= cfg_data;
                REG_HEIGHT_LIMIT: height_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode;
            w_reg    <= req_width;
            h_reg    <= req_height;
            tgt_reg  <= target_handle;
            idle_reg <= idle_limit_ms;
            now_reg  <= now_ms;
        end
    end

    // Scan, commit and bookkeeping
    always_comb
    begin
        valid_next       = valid_reg;
        busy_next        = busy_reg;
        cnt_valid_next   = cnt_valid_reg;
        cnt_busy_next    = cnt_busy_reg;
        next_handle_next = next_handle_reg;
        active_next      = active_reg;
        cnt_next         = cnt_reg;
        kind_next        = kind_reg;
        m_found_next     = m_found_reg;
        m_idx_next       = m_idx_reg;
        m_hd_next        = m_hd_reg;
        v_found_next     = v_found_reg;
        v_idx_next       = v_idx_reg;
        v_lu_next        = v_lu_reg;
        v_hd_next        = v_hd_reg;
        f_found_next     = f_found_reg;
        f_idx_next       = f_idx_reg;
        h_found_next     = h_found_reg;
        h_idx_next       = h_idx_reg;
        s1_idx_next      = s1_idx_reg;
        res_status_next  = res_status_reg;
        res_first_next   = res_first_reg;
        res_second_next  = res_second_reg;
        freed_next       = freed_reg;
        geom_we          = 1'b0;
        geom_wa          = pick;
        geom_wd          = '{width: w_reg, height: h_reg, handle: next_handle_reg};
        lu_we            = 1'b0;
        lu_wa            = rd_addr;

        if (cmd.latch)
        begin
            res_status_next = ST_OK;
            res_first_next  = '0;
            res_second_next = '0;
            freed_next      = '0;
        end

        if (cmd.set_size)
            res_status_next = ST_SIZE;

        // scan start clears the running results; a sweep also clears all busy flags
        if (cmd.scan_start)
        begin
            active_next  = 1'b1;
            cnt_next     = '0;
            kind_next    = cmd.scan_kind;
            m_found_next = 1'b0;
            v_found_next = 1'b0;
            f_found_next = 1'b0;
            h_found_next = 1'b0;
            if (cmd.scan_kind == KIND_SWEEP)
            begin
                busy_next     = '0;
                cnt_busy_next = '0;
            end
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (sts.scan_done)
                active_next = 1'b0;
            if (kind_reg == KIND_SWEEP && rd_en)
                lu_we = 1'b1;
            if (proc_en)
            begin
                case (kind_reg)
                    KIND_ACQ:
                    begin
                        if (valid_reg[proc_idx] && !busy_reg[proc_idx])
                        begin
                            if (geom_rd_reg.width == w_reg && geom_rd_reg.height == h_reg &&
                                (!m_found_reg || geom_rd_reg.handle < m_hd_reg))
                            begin
                                m_found_next = 1'b1;
                                m_idx_next   = proc_idx;
                                m_hd_next    = geom_rd_reg.handle;
                            end
                            if (!v_found_reg || lu_rd_reg < v_lu_reg ||
                                (lu_rd_reg == v_lu_reg && geom_rd_reg.handle < v_hd_reg))
                            begin
                                v_found_next = 1'b1;
                                v_idx_next   = proc_idx;
                                v_lu_next    = lu_rd_reg;
                                v_hd_next    = geom_rd_reg.handle;
                            end
                        end
                        if (!valid_reg[proc_idx] && !f_found_reg)
                        begin
                            f_found_next = 1'b1;
                            f_idx_next   = proc_idx;
                        end
                    end
                    KIND_REL:
                    begin
                        if (valid_reg[proc_idx] && geom_rd_reg.handle == tgt_reg &&
                            !h_found_reg)
                        begin
                            h_found_next = 1'b1;
                            h_idx_next   = proc_idx;
                        end
                    end
                    KIND_TRIM:
                    begin
                        if (valid_reg[proc_idx] && !busy_reg[proc_idx] &&
                            now_reg > lu_rd_reg && (now_reg - lu_rd_reg) > idle_reg)
                        begin
                            valid_next[proc_idx] = 1'b0;
                            cnt_valid_next       = cnt_valid_reg - CW'(1);
                            freed_next           = freed_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // acquire commit: reuse, create with optional eviction, or report full
        if (cmd.commit)
        begin
            if (m_found_reg)
            begin
                busy_next[m_idx_reg] = 1'b1;
                cnt_busy_next        = cnt_busy_reg + CW'(1);
                lu_we                = 1'b1;
                lu_wa                = m_idx_reg;
                if (cmd.second)
                    res_second_next = m_hd_reg;
                else
                begin
                    res_first_next = m_hd_reg;
                    s1_idx_next    = m_idx_reg;
                end
            end
            else if ((evict && !v_found_reg) || (!evict && !f_found_reg))
            begin
                res_status_next = ST_FULL;
                if (cmd.second)
                begin
                    // undo the first of the pair
                    res_first_next        = '0;
                    busy_next[s1_idx_reg] = 1'b0;
                    cnt_busy_next         = cnt_busy_reg - CW'(1);
                    lu_we                 = 1'b1;
                    lu_wa                 = s1_idx_reg;
                end
            end
            else
            begin
                if (evict)
                    valid_next[v_idx_reg] = 1'b0;
                else
                    cnt_valid_next = cnt_valid_reg + CW'(1);
                valid_next[pick] = 1'b1;
                busy_next[pick]  = 1'b1;
                cnt_busy_next    = cnt_busy_reg + CW'(1);
                geom_we          = 1'b1;
                lu_we            = 1'b1;
                lu_wa            = pick;
                next_handle_next = nh_inc;
                if (cmd.second)
                    res_second_next = next_handle_reg;
                else
                begin
                    res_first_next = next_handle_reg;
                    s1_idx_next    = pick;
                end
            end
        end

        // release by handle
        if (cmd.rel_commit)
        begin
            if (!h_found_reg)
                res_status_next = ST_UNKNOWN;
            else if (!busy_reg[h_idx_reg])
                res_status_next = ST_IDLE;
            else
            begin
                busy_next[h_idx_reg] = 1'b0;
                cnt_busy_next        = cnt_busy_reg - CW'(1);
                lu_we                = 1'b1;
                lu_wa                = h_idx_reg;
            end
        end

        // clear everything
        if (cmd.clear_all)
        begin
            freed_next     = cnt_valid_reg;
            valid_next     = '0;
            busy_next      = '0;
            cnt_valid_next = '0;
            cnt_busy_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            busy_reg        <= '0;
            cnt_valid_reg   <= '0;
            cnt_busy_reg    <= '0;
            next_handle_reg <= 32'd1;
            active_reg      <= 1'b0;
            cnt_reg         <= '0;
            kind_reg        <= KIND_ACQ;
            m_found_reg     <= 1'b0;
            v_found_reg     <= 1'b0;
            f_found_reg     <= 1'b0;
            h_found_reg     <= 1'b0;
            res_status_reg  <= ST_OK;
        end
        else
        begin
            valid_reg       <= valid_next;
            busy_reg        <= busy_next;
            cnt_valid_reg   <= cnt_valid_next;
            cnt_busy_reg    <= cnt_busy_next;
            next_handle_reg <= next_handle_next;
            active_reg      <= active_next;
            cnt_reg         <= cnt_next;
            kind_reg        <= kind_next;
            m_found_reg     <= m_found_next;
            v_found_reg     <= v_found_next;
            f_found_reg     <= f_found_next;
            h_found_reg     <= h_found_next;
            res_status_reg  <= res_status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        m_idx_reg      <= m_idx_next;
        m_hd_reg       <= m_hd_next;
        v_idx_reg      <= v_idx_next;
        v_lu_reg       <= v_lu_next;
        v_hd_reg       <= v_hd_next;
        f_idx_reg      <= f_idx_next;
        h_idx_reg      <= h_idx_next;
        s1_idx_reg     <= s1_idx_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        freed_reg      <= freed_next;
    end

    // Slot geometry memory
    always_ff @(posedge clk)
    begin
        if (geom_we)
            geom_mem[geom_wa] <= geom_wd;
        if (rd_en)
            geom_rd_reg <= geom_mem[rd_addr];
    end

    // Last-use time memory
    always_ff @(posedge clk)
    begin
        if (lu_we)
            lu_mem[lu_wa] <= now_reg;
        if (rd_en)
            lu_rd_reg <= lu_mem[rd_addr];
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status        <= res_status_reg;
            first_handle  <= res_first_reg;
            second_handle <= res_second_reg;
            freed_count   <= 5'(freed_reg);
            entries_total <= 5'(cnt_valid_reg);
            entries_busy  <= 5'(cnt_busy_reg);
        end
    end

    a_busy_le_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_busy_reg <= cnt_valid_reg)
        else $error("busy count exceeds entry count");

    a_busy_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg & ~valid_reg) == '0)
        else $error("busy flag set on an empty slot");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_valid_reg) == $countones(valid_reg))
        else $error("entry count out of step with valid flags");

    a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_handle_reg != '0)
        else $error("handle counter reached zero");

endmodule

// ----- rtl/render_target_pool_lru.sv -----
// Top level of the render target pool: sequencer plus slot datapath.
// Clear, bad size and unused opcodes skip the slot scan; release all and trim scan once;
// acquire and release add a commit after it; acquire pair adds a second scan and commit
// when its first acquire succeeds. One word in flight: the next word is taken from the
// cycle after the result loads; a stalled result holds the sequencer. Reset empties the
// pool, sets handle 1 and default limits.
module render_target_pool_lru_core
    import rtpl_pkg::*;
#(
    parameter int POOL_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [13:0] req_width,
    input  logic [13:0] req_height,
    input  logic [31:0] target_handle,
    input  logic [31:0] idle_limit_ms,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] first_handle,
    output logic [31:0] second_handle,
    output logic [4:0]  freed_count,
    output logic [4:0]  entries_total,
    output logic [4:0]  entries_busy
);

    cmd_t cmd;
    sts_t sts;

    // Limits change only between words
    assign cfg_ready = !in_stall;

    rtpl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rtpl_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .req_width     (req_width),
        .req_height    (req_height),
        .target_handle (target_handle),
        .idle_limit_ms (idle_limit_ms),
        .now_ms        (now_ms),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .first_handle  (first_handle),
        .second_handle (second_handle),
        .freed_count   (freed_count),
        .entries_total (entries_total),
        .entries_busy  (entries_busy)
    );

endmodule

// ----- bench/tb_render_target_pool_lru_core.sv -----
// Self-checking testbench for the render target pool: directed and random operations.
module tb_render_target_pool_lru_core
    import rtpl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] first_hd;
        logic [31:0] second_hd;
        logic [4:0]  freed;
        logic [4:0]  total;
        logic [4:0]  busy;
    } pool_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [13:0] req_width;
    logic [13:0] req_height;
    logic [31:0] target_handle;
    logic [31:0] idle_limit_ms;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] first_handle;
    logic [31:0] second_handle;
    logic [4:0]  freed_count;
    logic [4:0]  entries_total;
    logic [4:0]  entries_busy;

    // Mirror of the slot table and registers
    bit          mir_valid [SLOTS];
    bit          mir_busy  [SLOTS];
    logic [13:0] mir_width [SLOTS];
    logic [13:0] mir_height[SLOTS];
    logic [31:0] mir_handle[SLOTS];
    logic [31:0] mir_used  [SLOTS];
    logic [31:0] mir_next;
    logic [4:0]  lim_pool;
    logic [13:0] lim_w;
    logic [13:0] lim_h;

    pool_result_t pool_results_q[$];
    int           errors;
    int           cycles;
    bit           tx_idle;
    bit           rx_idle;
    bit           rx_hold_req;
    logic [31:0]  clock_ms;

    render_target_pool_lru_core u_top (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Entry order: lowest handle, then lowest slot
    function automatic bit ahead(input int a, input int b);
        if (mir_handle[a] != mir_handle[b])
            return mir_handle[a] < mir_handle[b];
        return a < b;
    endfunction

    function automatic logic [4:0] count_total();
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (mir_valid[i]) n++;
        return n;
    endfunction

    function automatic logic [4:0] count_busy();
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (mir_valid[i] && mir_busy[i]) n++;
        return n;
    endfunction

    // Acquire one target; slot gets the slot used or -1
    function automatic logic [2:0] take_target(input logic [13:0] w, input logic [13:0] h,
                                               input logic [31:0] now, output int slot);
        int          pick;
        int          victim;
        int          lim;
        logic [13:0] wl;
        logic [13:0] hl;
        slot = -1;
        pick = -1;
        victim = -1;
        wl = (lim_w == 0) ? 14'd1 : lim_w;
        hl = (lim_h == 0) ? 14'd1 : lim_h;
        lim = (lim_pool < 1) ? 1 : (lim_pool > SLOTS) ? SLOTS : int'(lim_pool);
        if (w > wl || h > hl)
            return ST_SIZE;
        for (int i = 0; i < SLOTS; i++)
            if (mir_valid[i] && !mir_busy[i] && mir_width[i] == w && mir_height[i] == h &&
                (pick < 0 || ahead(i, pick)))
                pick = i;
        if (pick < 0)
        begin
            if (int'(count_total()) >= lim)
            begin
                // evict least recently used idle entry
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!mir_valid[i] || mir_busy[i])
                        continue;
                    if (victim < 0 || mir_used[i] < mir_used[victim] ||
                        (mir_used[i] == mir_used[victim] && ahead(i, victim)))
                        victim = i;
                end
                if (victim < 0)
                    return ST_FULL;
                mir_valid[victim] = 0;
                mir_busy[victim] = 0;
            end
            for (int i = 0; i < SLOTS; i++)
                if (!mir_valid[i])
                begin
                    pick = i;
                    break;
                end
            if (pick < 0)
                return ST_FULL;
            mir_valid[pick] = 1;
            mir_width[pick] = w;
            mir_height[pick] = h;
            mir_handle[pick] = mir_next;
            mir_next = mir_next + 1;
            if (mir_next == 0)
                mir_next = 1;
        end
        mir_busy[pick] = 1;
        mir_used[pick] = now;
        slot = pick;
        return ST_OK;
    endfunction

    // Work out the result of one operation and update the mirror
    function automatic pool_result_t pool_outcome(input logic [2:0] op, input logic [13:0] w,
                                                  input logic [13:0] h, input logic [31:0] hd,
                                                  input logic [31:0] idle_lim,
                                                  input logic [31:0] now);
        pool_result_t r;
        int           s1;
        int           s2;
        int           hit;
        r = '{ST_OK, 0, 0, 0, 0, 0};
        hit = -1;
        case (op)
            OP_ACQUIRE:
            begin
                r.status = take_target(w, h, now, s1);
                if (r.status == ST_OK)
                    r.first_hd = mir_handle[s1];
            end
            OP_PAIR:
            begin
                r.status = take_target(w, h, now, s1);
                if (r.status == ST_OK)
                begin
                    r.status = take_target(w, h, now, s2);
                    if (r.status != ST_OK)
                    begin
                        // undo the first
                        mir_busy[s1] = 0;
                        mir_used[s1] = now;
                    end
                    else
                    begin
                        r.first_hd = mir_handle[s1];
                        r.second_hd = mir_handle[s2];
                    end
                end
            end
            OP_RELEASE:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (mir_valid[i] && mir_handle[i] == hd)
                    begin
                        hit = i;
                        break;
                    end
                if (hit < 0)
                    r.status = ST_UNKNOWN;
                else if (!mir_busy[hit])
                    r.status = ST_IDLE;
                else
                begin
                    mir_busy[hit] = 0;
                    mir_used[hit] = now;
                end
            end
            OP_REL_ALL:
                for (int i = 0; i < SLOTS; i++)
                    if (mir_valid[i])
                    begin
                        mir_busy[i] = 0;
                        mir_used[i] = now;
                    end
            OP_TRIM:
                for (int i = 0; i < SLOTS; i++)
                    if (mir_valid[i] && !mir_busy[i] && now > mir_used[i] &&
                        (now - mir_used[i]) > idle_lim)
                    begin
                        mir_valid[i] = 0;
                        r.freed++;
                    end
            OP_CLEAR:
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (mir_valid[i])
                        r.freed++;
                    mir_valid[i] = 0;
                    mir_busy[i] = 0;
                end
            default: ;
        endcase
        r.total = count_total();
        r.busy = count_busy();
        return r;
    endfunction

    // Send one word and queue its expected result on acceptance
    task automatic send_op(input logic [2:0] op, input logic [13:0] w, input logic [13:0] h,
                           input logic [31:0] hd, input logic [31:0] idle_lim,
                           input logic [31:0] now);
        int gap;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        req_width     <= w;
        req_height    <= h;
        target_handle <= hd;
        idle_limit_ms <= idle_lim;
        now_ms        <= now;
        do
            @(posedge clk);
        while (in_stall);
        pool_results_q.insert(pool_results_q.size(),
                              pool_outcome(op, w, h, hd, idle_lim, now));
    endtask

    // Wait for all results, then for the block to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pool_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic cfg_write(input logic [1:0] idx, input logic [13:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_POOL_LIMIT:   lim_pool = data[4:0];
            REG_WIDTH_LIMIT:  lim_w = data;
            REG_HEIGHT_LIMIT: lim_h = data;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [13:0] pool, input logic [13:0] w,
                              input logic [13:0] h);
        drain();
        cfg_write(REG_POOL_LIMIT, pool);
        cfg_write(REG_WIDTH_LIMIT, w);
        cfg_write(REG_HEIGHT_LIMIT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        pool_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pool_results_q.size() == 0)
                report_mismatch("unexpected word", 32'(status), 32'd0);
            else
            begin
                e = pool_results_q.pop_front();
                if (status !== e.status)
                    report_mismatch("status", 32'(status), 32'(e.status));
                if (first_handle !== e.first_hd)
                    report_mismatch("first", first_handle, e.first_hd);
                if (second_handle !== e.second_hd)
                    report_mismatch("second", second_handle, e.second_hd);
                if (freed_count !== e.freed)
                    report_mismatch("freed", 32'(freed_count), 32'(e.freed));
                if (entries_total !== e.total)
                    report_mismatch("total", 32'(entries_total), 32'(e.total));
                if (entries_busy !== e.busy)
                    report_mismatch("busy", 32'(entries_busy), 32'(e.busy));
            end
        end
    end

    // Receiver: per-word stall, or one long hold on request
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
                gap = HOLD_CYCLES;
            else
                gap = rx_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                rx_hold_req = 0;
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Random size: mostly a few small sizes so reuse happens
    function automatic logic [13:0] pick_dim(input logic [13:0] lim);
        case ($urandom_range(0, 9))
            0:       return 14'($urandom_range(0, 16383));
            1:       return lim;
            2:       return lim + 14'd1;
            default: return 14'($urandom_range(0, 3));
        endcase
    endfunction

    // Handle of a live entry most of the time
    function automatic logic [31:0] pick_handle();
        logic [31:0] live[$];
        for (int i = 0; i < SLOTS; i++)
            if (mir_valid[i]) live.insert(live.size(), mir_handle[i]);
        if (live.size() == 0 || $urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, mir_next + 2);
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic random_ops(input int n);
        int          k;
        logic [2:0]  op;
        logic [31:0] idle_lim;
        logic [31:0] now;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)      op = OP_ACQUIRE;
            else if (k < 55) op = OP_PAIR;
            else if (k < 77) op = OP_RELEASE;
            else if (k < 82) op = OP_REL_ALL;
            else if (k < 94) op = OP_TRIM;
            else if (k < 97) op = OP_CLEAR;
            else             op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
            clock_ms = clock_ms + $urandom_range(0, 40);
            now = ($urandom_range(0, 15) == 0) ? $urandom() : clock_ms;
            idle_lim = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 120);
            send_op(op, pick_dim(lim_w), pick_dim(lim_h), pick_handle(), idle_lim, now);
        end
    endtask

    // Directed corner cases with a pool of three
    task automatic test_directed();
        set_limits(14'd3, 14'd4096, 14'd4096);
        send_op(OP_ACQUIRE, 0, 0, 0, 0, 10);
        send_op(OP_ACQUIRE, 14'h3FFF, 14'h3FFF, 0, 0, 11);
        send_op(OP_ACQUIRE, 4096, 4096, 0, 0, 11);
        send_op(OP_ACQUIRE, 4097, 4096, 0, 0, 11);
        send_op(OP_PAIR, 4096, 4097, 0, 0, 11);
        send_op(OP_PAIR, 5, 5, 0, 0, 12);      // second fails, first undone
        send_op(OP_RELEASE, 0, 0, 1, 0, 20);
        send_op(OP_RELEASE, 0, 0, 1, 0, 21);   // already idle
        send_op(OP_RELEASE, 0, 0, 0, 0, 21);   // handle zero unknown
        send_op(OP_RELEASE, 0, 0, 32'hFFFF_FFFF, 0, 21);
        send_op(OP_ACQUIRE, 7, 7, 0, 0, 30);   // evicts oldest idle
        send_op(OP_ACQUIRE, 0, 0, 0, 0, 31);   // reuses the idle match
        send_op(OP_REL_ALL, 0, 0, 0, 0, 40);
        send_op(OP_TRIM, 0, 0, 0, 5, 35);      // time went backwards
        send_op(OP_TRIM, 0, 0, 0, 0, 40);      // equal time, kept
        send_op(OP_TRIM, 0, 0, 0, 0, 41);
        send_op(OP_PAIR, 2, 2, 0, 0, 50);
        send_op(OP_PAIR, 2, 2, 0, 0, 51);
        send_op(OP_SPARE6, 1, 1, 1, 1, 52);
        send_op(OP_SPARE7, 1, 1, 1, 1, 52);
        send_op(OP_CLEAR, 0, 0, 0, 0, 60);     // removes busy entries too
        send_op(OP_ACQUIRE, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_op(OP_RELEASE, 0, 0, 32'd8, 0, 32'hFFFF_FFFF);
        send_op(OP_TRIM, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_TRIM, 0, 0, 0, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Random traffic at several register settings
    task automatic test_random_limits();
        tx_idle = 1; rx_idle = 1;
        set_limits(14'd16, 14'd4096, 14'd4096);
        random_ops(400);
        set_limits(14'd1, 14'd1, 14'd1);
        random_ops(200);
        set_limits(14'd31, 14'h3FFF, 14'h3FFF);
        random_ops(300);
        set_limits(14'd0, 14'd0, 14'd0);
        random_ops(150);
        tx_idle = 0; rx_idle = 0;
        set_limits(14'd4, 14'd100, 14'd200);
        random_ops(250);
        tx_idle = 1; rx_idle = 0;
        random_ops(100);
        tx_idle = 0; rx_idle = 1;
        random_ops(100);
    endtask

    // Receiver holds off while words keep coming, then sender waits for all results
    task automatic test_backpressure();
        tx_idle = 0; rx_idle = 1;
        set_limits(14'd8, 14'd64, 14'd64);
        rx_hold_req = 1;
        random_ops(60);
        drain();
        tx_idle = 1;
        random_ops(265);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_POOL_LIMIT;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_ACQUIRE;
        req_width = '0;
        req_height = '0;
        target_handle = '0;
        idle_limit_ms = '0;
        now_ms = '0;
        errors = 0;
        cycles = 0;
        tx_idle = 1;
        rx_idle = 1;
        rx_hold_req = 0;
        clock_ms = 100;
        for (int i = 0; i < SLOTS; i++)
        begin
            mir_valid[i] = 0;
            mir_busy[i] = 0;
        end
        mir_next = 1;
        lim_pool = POOL_LIMIT_RST;
        lim_w = DIM_LIMIT_RST;
        lim_h = DIM_LIMIT_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_limits();
        test_backpressure();

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rtpl_pkg.sv
rtl/rtpl_ctrl.sv
rtl/rtpl_datapath.sv
rtl/render_target_pool_lru.sv
bench/tb_render_target_pool_lru_core.sv
